@@ hdl/sas_pkg.sv @@
// ----------------------------------------------------------------------------
// sas_pkg: shared types and codes for the shifting array store
// Command and status codes, and the packed beat types of both channels.
// ----------------------------------------------------------------------------
package sas_pkg;

  // command codes
  localparam logic [2:0] CMD_READ   = 3'd0;
  localparam logic [2:0] CMD_INSERT = 3'd1;
  localparam logic [2:0] CMD_DELETE = 3'd2;
  localparam logic [2:0] CMD_SEARCH = 3'd3;
  localparam logic [2:0] CMD_UPDATE = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [2:0]         command;
    logic [5:0]         position;
    logic signed [31:0] operand_value;
  } sas_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [5:0]         found_index;
    logic signed [31:0] read_value;
    logic [6:0]         entry_count;
  } sas_out_t;

endpackage

@@ hdl/sas_ram.sv @@
// ----------------------------------------------------------------------------
// sas_ram: generic simple dual-port RAM
// One write port, one read port, read data registered. No reset on contents.
// ----------------------------------------------------------------------------
module sas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/shifting_array_store.sv @@
// ----------------------------------------------------------------------------
// shifting_array_store: dense array with insert, delete, search and update
// Keeps up to DEPTH signed 32-bit words packed from index 0 and a count of
// the entries in use. Each input beat carries one command and yields
// exactly one result beat.
// ----------------------------------------------------------------------------
// Every command goes through one RAM with one write and one registered read
// port, so the block moves or compares one entry per cycle and takes one
// command at a time (in_stall is high from acceptance until the result is
// loaded into the output register). Read and update touch one entry; an
// insert at index p moves the entries from the top down to p up by one and
// then writes the new value (an append just writes it); a delete at p moves
// the entries above p down (the last entry is just dropped); a search scans
// from index 0 until the first match. The output register frees the input
// side: a new command is accepted while the previous result still waits on
// out_stall. Bad requests (index at or past the count, insert into a full
// store) and searches with no match are flagged in status and leave the
// store untouched. Only the lowest 64 indices are addressable; entry_count
// reports the low 7 bits of the count.
// ----------------------------------------------------------------------------
module shifting_array_store #(
  parameter int DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sas_pkg::sas_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sas_pkg::sas_out_t out_data
);

  import sas_pkg::*;

  localparam int AW = $clog2(DEPTH);        // entry address
  localparam int CW = $clog2(DEPTH + 1);    // count, holds DEPTH itself
  localparam int PW = (CW > 6) ? CW : 6;    // width for index vs count compares

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_REQ,
    S_RD_WAIT,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_DRAIN,
    S_WR_VAL,
    S_SEARCH,
    S_SRCH_TAIL,
    S_EMIT
  } state_t;

  state_t             state_r;
  logic [2:0]         cmd_r;
  logic [5:0]         pos_r;
  logic signed [31:0] val_r;
  logic [CW-1:0]      cnt_r;
  logic [AW-1:0]      rp_r;          // RAM read pointer
  logic               pend_r;        // shifted word waiting to be written
  logic [AW-1:0]      pend_addr_r;
  logic               cmp_valid_r;   // search: read data is live this cycle
  logic [AW-1:0]      cmp_idx_r;
  logic [1:0]         res_status_r;
  logic [AW-1:0]      res_found_r;
  logic signed [31:0] res_rdval_r;
  logic               out_valid_r;
  sas_out_t           out_data_r;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [31:0]        mem_wdata;
  logic [31:0]        mem_rdata;
  logic [PW-1:0]      in_pos_w;
  logic [PW-1:0]      cnt_w;
  logic [AW-1:0]      last_a;
  logic               in_accept;
  logic               hit;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign in_pos_w  = PW'(in_data.position);
  assign cnt_w     = PW'(cnt_r);
  assign last_a    = AW'(cnt_r - CW'(1));
  assign hit       = cmp_valid_r && (mem_rdata == val_r);

  // Shifted words take the write port first; the new value goes in after
  // the shift has drained.
  assign mem_we    = pend_r || (state_r == S_WR_VAL);
  assign mem_waddr = pend_r ? pend_addr_r : AW'(pos_r);
  assign mem_wdata = pend_r ? mem_rdata : val_r;

  sas_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rp_r),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          cmp_valid_r <= 1'b0;
          if (in_accept) begin
            cmd_r        <= in_data.command;
            pos_r        <= in_data.position;
            val_r        <= in_data.operand_value;
            res_status_r <= ST_OK;
            res_found_r  <= '0;
            res_rdval_r  <= '0;
            state_r      <= S_EMIT;
            unique case (in_data.command)
              CMD_READ: begin
                if (in_pos_w < cnt_w) begin
                  rp_r    <= AW'(in_data.position);
                  state_r <= S_RD_REQ;
                end else begin
                  res_status_r <= ST_RANGE;
                end
              end
              CMD_INSERT: begin
                if (in_pos_w > cnt_w) begin
                  res_status_r <= ST_RANGE;
                end else if (cnt_r == CW'(DEPTH)) begin
                  res_status_r <= ST_FULL;
                end else if (in_pos_w == cnt_w) begin
                  state_r <= S_WR_VAL;     // append, nothing to move
                end else begin
                  rp_r    <= last_a;       // move from the top down
                  state_r <= S_SHIFT_UP;
                end
              end
              CMD_DELETE: begin
                if (in_pos_w >= cnt_w) begin
                  res_status_r <= ST_RANGE;
                end else if (in_pos_w + PW'(1) == cnt_w) begin
                  cnt_r <= cnt_r - CW'(1); // last entry, just drop it
                end else begin
                  rp_r    <= AW'(in_data.position) + AW'(1);
                  state_r <= S_SHIFT_DN;
                end
              end
              CMD_SEARCH: begin
                if (cnt_r == '0) begin
                  res_status_r <= ST_NOTFOUND;
                end else begin
                  rp_r    <= '0;
                  state_r <= S_SEARCH;
                end
              end
              CMD_UPDATE: begin
                if (in_pos_w < cnt_w) begin
                  state_r <= S_WR_VAL;
                end else begin
                  res_status_r <= ST_RANGE;
                end
              end
              default: begin
                // unused codes: no change, status ok
              end
            endcase
          end
        end

        S_RD_REQ: begin
          state_r <= S_RD_WAIT;
        end

        S_RD_WAIT: begin
          res_rdval_r <= mem_rdata;
          state_r     <= S_EMIT;
        end

        // entries[rp+1] = entries[rp], rp walking down to pos
        S_SHIFT_UP: begin
          pend_r      <= 1'b1;
          pend_addr_r <= rp_r + AW'(1);
          if (rp_r == AW'(pos_r)) begin
            state_r <= S_DRAIN;
          end else begin
            rp_r <= rp_r - AW'(1);
          end
        end

        // entries[rp-1] = entries[rp], rp walking up to count-1
        S_SHIFT_DN: begin
          pend_r      <= 1'b1;
          pend_addr_r <= rp_r - AW'(1);
          if (rp_r == last_a) begin
            state_r <= S_DRAIN;
          end else begin
            rp_r <= rp_r + AW'(1);
          end
        end

        // last shifted word is written this cycle
        S_DRAIN: begin
          if (cmd_r == CMD_INSERT) begin
            state_r <= S_WR_VAL;
          end else begin
            cnt_r   <= cnt_r - CW'(1);
            state_r <= S_EMIT;
          end
        end

        S_WR_VAL: begin
          if (cmd_r == CMD_INSERT) begin
            cnt_r <= cnt_r + CW'(1);
          end
          state_r <= S_EMIT;
        end

        // read one entry a cycle, compare the one read the cycle before
        S_SEARCH: begin
          if (hit) begin
            res_found_r <= cmp_idx_r;
            cmp_valid_r <= 1'b0;
            state_r     <= S_EMIT;
          end else begin
            cmp_valid_r <= 1'b1;
            cmp_idx_r   <= rp_r;
            if (rp_r == last_a) begin
              state_r <= S_SRCH_TAIL;
            end else begin
              rp_r <= rp_r + AW'(1);
            end
          end
        end

        S_SRCH_TAIL: begin
          cmp_valid_r <= 1'b0;
          if (hit) begin
            res_found_r <= cmp_idx_r;
          end else begin
            res_status_r <= ST_NOTFOUND;
          end
          state_r <= S_EMIT;
        end

        // wait for the output register to free up
        S_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r             <= 1'b1;
            out_data_r.status       <= res_status_r;
            out_data_r.found_index  <= 6'(res_found_r);
            out_data_r.read_value   <= res_rdval_r;
            out_data_r.entry_count  <= 7'(cnt_r);
            state_r                 <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------

  // count never passes the store size
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count above DEPTH");

  // a drained shift word and the new value never fight for the write port
  a_wr_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(pend_r && (state_r == S_WR_VAL)))
    else $error("write port conflict");

  // one command at a time: busy right after acceptance
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> in_stall)
    else $error("input taken while busy");

  // count only moves while a command is in flight
  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !in_valid) |=> $stable(cnt_r))
    else $error("count changed while idle");

endmodule
